FILE: rtl/tcpt_pkg.sv
package tcpt_pkg;

    localparam int NUM_TIMERS = 3;
    localparam int TIDX_W     = 2;

    // Item kinds carried on s_tuser
    localparam logic [2:0] FUNC_READ  = 3'd0;
    localparam logic [2:0] FUNC_WRITE = 3'd1;
    localparam logic [2:0] FUNC_ETICK = 3'd2;
    localparam logic [2:0] FUNC_EXTCK = 3'd3;
    localparam logic [2:0] FUNC_GATE  = 3'd4;

    // Register offsets with a fixed meaning
    localparam logic [2:0] ADDR_CTRL13  = 3'd0;
    localparam logic [2:0] ADDR_STATUS  = 3'd1;

    localparam logic [7:0] READ_IDLE_BYTE = 8'hFF;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // Next-state of one counter after one decrement step
    typedef struct packed {
        logic [15:0] count;
        logic        level;
        logic        hit;
    } tcpt_cnt_t;

endpackage

FILE: rtl/tcpt_counter.sv
module tcpt_counter
    import tcpt_pkg::*;
(
    input  logic [15:0] count_value,
    input  logic [15:0] latch_value,
    input  logic [7:0]  control,
    input  logic        level,
    output tcpt_cnt_t   result
);

    always_comb begin
        logic [15:0] c;
        logic        hit;
        logic        lvl;
        c   = count_value;
        hit = 1'b0;
        lvl = level;
        if (control[2]) begin
            // 16-bit mode: toggle on underflow
            if (c == 16'h0000) begin
                hit = 1'b1;
                lvl = ~lvl;
            end
            c = c - 16'd1;
        end else begin
            // dual 8-bit mode
            if (c[7:0] != 8'h00) begin
                c = c - 16'd1;
            end else if (c[15:8] != 8'h00) begin
                c = {c[15:8] - 8'd1, latch_value[7:0]};
            end else begin
                c   = 16'h0000;
                hit = 1'b1;
            end
        end
        // continuous modes reload, one-shot modes keep the wrapped value
        if (hit && !control[5]) begin
            c = latch_value;
        end
        if (!control[2]) begin
            lvl = (c[15:8] == 8'h00);
        end
        result.count = c;
        result.level = lvl;
        result.hit   = hit;
    end

endmodule

FILE: rtl/three_channel_programmable_timer_core.sv
// Three-timer programmable timer core.
// Each input transfer carries one bus item: s_tuser holds the kind (read, write,
// E clock tick, external clock, gate falling edge), s_tdata holds the register
// offset, the write byte and the timer select. Each input transfer produces
// exactly one result transfer on the m_ side: the read byte (zero for items
// other than reads), the interrupt request and the three gated output pins.
// An accepted item waits in the input register and moves on to the result
// register once that register is free. Throughput: one item per cycle while
// m_tready is high; all state update for an item is combinational between
// the input and result registers, so back-to-back items see each other's
// effects in order. When the receiver stalls, the result holds in the output
// register and one more item may be taken into the input register; then
// s_tready drops until m_tready returns. No item is lost or duplicated.
// Reset (aresetn low, synchronous) sets counters and latches to 0xFFFF,
// clears control words, output levels, status, byte buffers and the timer-3
// prescaler, and empties both pipeline registers.
module three_channel_programmable_timer_core
    import tcpt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [2:0] bus_address, [10:3] write_data, [12:11] timer_select, [15:13] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [2:0] func
    input  logic [2:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] read_data, [8] irq, [11:9] out_pins, [15:12] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    // input register
    logic                 in_valid_reg;
    logic [2:0]           in_func_reg;
    logic [2:0]           in_addr_reg;
    logic [7:0]           in_data_reg;
    logic [TIDX_W-1:0]    in_sel_reg;

    // result register
    logic                 out_valid_reg;
    logic [7:0]           out_rd_reg;
    logic                 out_irq_reg;
    logic [2:0]           out_pins_reg;

    // timer state
    logic [15:0] count_reg   [NUM_TIMERS];
    logic [15:0] latch_reg   [NUM_TIMERS];
    logic [7:0]  ctrl_reg    [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] level_reg;
    logic [NUM_TIMERS-1:0] flag_reg;
    logic        irq_reg;
    logic [7:0]  hbuf_reg;
    logic [7:0]  lbuf_reg;
    logic [2:0]  pre_reg;

    logic [15:0] count_next  [NUM_TIMERS];
    logic [15:0] latch_next  [NUM_TIMERS];
    logic [7:0]  ctrl_next   [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] level_next;
    logic [NUM_TIMERS-1:0] flag_next;
    logic        irq_next;
    logic [7:0]  hbuf_next;
    logic [7:0]  lbuf_next;
    logic [2:0]  pre_next;
    logic [7:0]  rd_next;
    logic [2:0]  pins_next;

    tcpt_cnt_t   cnt_res [NUM_TIMERS];

    logic advance;

    // move the held item into the result register when that register frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_pins_reg, out_irq_reg, out_rd_reg};

    // one decrement unit per timer, all fed with current state
    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cnt
        tcpt_counter u_cnt (
            .count_value (count_reg[g]),
            .latch_value (latch_reg[g]),
            .control     (ctrl_reg[g]),
            .level       (level_reg[g]),
            .result      (cnt_res[g])
        );
    end

    always_comb begin
        logic [TIDX_W-1:0] at;
        logic [TIDX_W-1:0] st;
        logic              go;
        logic [2:0]        pre_inc;
        at      = in_addr_reg[2:1] - 2'd1;
        st      = in_sel_reg - 2'd1;
        go      = 1'b1;
        pre_inc = pre_reg + 3'd1;

        for (int i = 0; i < NUM_TIMERS; i++) begin
            count_next[i] = count_reg[i];
            latch_next[i] = latch_reg[i];
            ctrl_next[i]  = ctrl_reg[i];
        end
        level_next = level_reg;
        flag_next  = flag_reg;
        hbuf_next  = hbuf_reg;
        lbuf_next  = lbuf_reg;
        pre_next   = pre_reg;
        rd_next    = 8'h00;

        case (in_func_reg)
            FUNC_READ: begin
                if (in_addr_reg == ADDR_CTRL13) begin
                    rd_next = READ_IDLE_BYTE;
                end else if (in_addr_reg == ADDR_STATUS) begin
                    rd_next = {irq_reg, 4'b0000, flag_reg};
                end else if (in_addr_reg[0]) begin
                    rd_next = lbuf_reg;
                end else begin
                    // counter read: latch the low byte, clear the timer's flag
                    for (int i = 0; i < NUM_TIMERS; i++) begin
                        if (TIDX_W'(i) == at) begin
                            rd_next      = count_reg[i][15:8];
                            lbuf_next    = count_reg[i][7:0];
                            flag_next[i] = 1'b0;
                        end
                    end
                end
            end
            FUNC_WRITE: begin
                if (in_addr_reg == ADDR_CTRL13) begin
                    if (ctrl_reg[1][0]) begin
                        ctrl_next[0] = in_data_reg;
                        // preset: copy every latch into its counter
                        if (in_data_reg[0]) begin
                            for (int i = 0; i < NUM_TIMERS; i++) begin
                                count_next[i] = latch_reg[i];
                            end
                        end
                    end else begin
                        ctrl_next[2] = in_data_reg;
                    end
                end else if (in_addr_reg == ADDR_STATUS) begin
                    ctrl_next[1] = in_data_reg;
                end else if (!in_addr_reg[0]) begin
                    hbuf_next = in_data_reg;
                end else begin
                    for (int i = 0; i < NUM_TIMERS; i++) begin
                        if (TIDX_W'(i) == at) begin
                            latch_next[i] = {hbuf_reg, in_data_reg};
                            if (ctrl_reg[i][4:3] == 2'b00) begin
                                count_next[i] = {hbuf_reg, in_data_reg};
                                level_next[i] = 1'b0;
                                flag_next[i]  = 1'b0;
                            end
                        end
                    end
                end
            end
            FUNC_ETICK: begin
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (ctrl_reg[i][1] && !ctrl_reg[i][3]) begin
                        count_next[i] = cnt_res[i].count;
                        level_next[i] = cnt_res[i].level;
                        if (cnt_res[i].hit) begin
                            flag_next[i] = 1'b1;
                        end
                    end
                end
            end
            FUNC_EXTCK: begin
                if (in_sel_reg != 2'd0) begin
                    // timer 3 prescaler: pass one clock in eight
                    if (st == 2'd2 && ctrl_reg[2][0]) begin
                        pre_next = pre_inc;
                        go       = (pre_inc == 3'd0);
                    end
                    for (int i = 0; i < NUM_TIMERS; i++) begin
                        if (TIDX_W'(i) == st && go && !ctrl_reg[i][1] && !ctrl_reg[i][3]) begin
                            count_next[i] = cnt_res[i].count;
                            level_next[i] = cnt_res[i].level;
                            if (cnt_res[i].hit) begin
                                flag_next[i] = 1'b1;
                            end
                        end
                    end
                end
            end
            FUNC_GATE: begin
                if (in_sel_reg != 2'd0) begin
                    for (int i = 0; i < NUM_TIMERS; i++) begin
                        if (TIDX_W'(i) == st && ctrl_reg[i][3]) begin
                            count_next[i] = latch_reg[i];
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        // interrupt and pins follow the updated state
        irq_next  = 1'b0;
        pins_next = 3'b000;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            if (flag_next[i] && ctrl_next[i][6]) begin
                irq_next = 1'b1;
            end
            pins_next[i] = level_next[i] & ctrl_next[i][7];
        end
    end

    // pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_func_reg <= s_tuser;
            in_addr_reg <= s_tdata[2:0];
            in_data_reg <= s_tdata[10:3];
            in_sel_reg  <= s_tdata[12:11];
        end
        if (advance) begin
            out_rd_reg   <= rd_next;
            out_irq_reg  <= irq_next;
            out_pins_reg <= pins_next;
        end
    end

    // timer state: commit only when the item moves to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                count_reg[i] <= 16'hFFFF;
                latch_reg[i] <= 16'hFFFF;
                ctrl_reg[i]  <= 8'h00;
            end
            level_reg <= '0;
            flag_reg  <= '0;
            irq_reg   <= 1'b0;
            hbuf_reg  <= 8'h00;
            lbuf_reg  <= 8'h00;
            pre_reg   <= 3'd0;
        end else if (advance) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                count_reg[i] <= count_next[i];
                latch_reg[i] <= latch_next[i];
                ctrl_reg[i]  <= ctrl_next[i];
            end
            level_reg <= level_next;
            flag_reg  <= flag_next;
            irq_reg   <= irq_next;
            hbuf_reg  <= hbuf_next;
            lbuf_reg  <= lbuf_next;
            pre_reg   <= pre_next;
        end
    end

endmodule
